### sv/frdf_pkg.sv
// Package for the frame deframer: result and configuration types, status codes,
// register indexes and the bytewise CRC-16/CCITT-FALSE update.
// Used by frdf_parser and frame_deframer_crc16; depends on nothing.
package frdf_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] POS_LIMIT = 16'hFFFF;
  localparam logic [15:0] MIN_FRAME = 16'd12;
  localparam logic [7:0] FAMILY_MAX = 8'd7;
  localparam logic [3:0] HDR_FIRST_POS = 4'd2;
  localparam logic [3:0] LEN_LOW_POS = 4'd8;
  localparam logic [3:0] LEN_HIGH_POS = 4'd9;
  localparam logic [15:0] PAYLOAD_POS = 16'd10;
  localparam int HDR_BYTES = 6;

  localparam logic [7:0] SYNC_FIRST_RST = 8'hAA;
  localparam logic [7:0] SYNC_SECOND_RST = 8'h55;
  localparam logic [7:0] MAJOR_RST = 8'd3;
  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd1024;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW = $clog2(FIFO_DEPTH);
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [2:0] {
    ST_OK             = 3'd0,
    ST_TRUNCATED      = 3'd1,
    ST_BAD_SYNC       = 3'd2,
    ST_TOO_LONG       = 3'd3,
    ST_BAD_CRC        = 3'd4,
    ST_BAD_MAJOR      = 3'd5,
    ST_UNKNOWN_FAMILY = 3'd6
  } frdf_status_e;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } frdf_kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SYNC_FIRST  = 2'd0,
    REG_SYNC_SECOND = 2'd1,
    REG_MAJOR       = 2'd2,
    REG_MAX_PAYLOAD = 2'd3
  } frdf_reg_e;

  typedef struct packed {
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [7:0]  supported_major;
    logic [15:0] max_payload;
  } frdf_cfg_t;

  typedef struct packed {
    frdf_kind_e   item_kind;
    logic [7:0]   payload_byte;
    frdf_status_e status_code;
    logic [7:0]   major_version;
    logic [7:0]   family_code;
    logic [7:0]   msg_kind;
    logic [7:0]   queue_sel;
    logic [7:0]   header_flags;
    logic [7:0]   sequence_no;
    logic [15:0]  payload_length;
    logic         run_last;
  } frdf_res_t;

  typedef struct packed {
    logic      pay_vld;
    frdf_res_t pay;
    logic      sts_vld;
    frdf_res_t sts;
  } frdf_push_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

### sv/frame_deframer_crc16.sv
// Top level of the frame deframer: configuration registers, parser and result queue.
// Depends on frdf_pkg and frdf_parser.
//
// Channel   Direction  Handshake                    Payload
// in        input      in_valid_i / in_ready_o      rx_byte_i, buffer_end_i
// out       output     out_valid_o / out_ready_i    item_kind_o .. run_last_o
// cfg       input      cfg_we_i (always taken)      cfg_idx_i, cfg_wdata_i
//
// Each accepted byte is parsed in the cycle it is taken and its zero, one or two results
// enter a four-entry queue; into an empty queue the first result shows on the next cycle.
// One byte per cycle is sustained while the queue has room for two results.
// A stalled output holds the queue head; input is refused when fewer than two slots are free.
// Reset clears the parser state, the queue and the registers to their defaults.
module frame_deframer_crc16
  import frdf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            rx_byte_i,
  input  logic                  buffer_end_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  item_kind_o,
  output logic [7:0]            payload_byte_o,
  output logic [2:0]            status_code_o,
  output logic [7:0]            major_version_o,
  output logic [7:0]            family_code_o,
  output logic [7:0]            msg_kind_o,
  output logic [7:0]            queue_sel_o,
  output logic [7:0]            header_flags_o,
  output logic [7:0]            sequence_no_o,
  output logic [15:0]           payload_length_o,
  output logic                  run_last_o
);

  frdf_cfg_t  cfg_q;
  frdf_push_t push;
  logic       in_acc;
  logic       pop;

  frdf_res_t          fifo_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_AW:0]   count_q;
  logic [1:0]         n_push;
  frdf_res_t          first_res;
  frdf_res_t          head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_first <= SYNC_FIRST_RST;
      cfg_q.sync_second <= SYNC_SECOND_RST;
      cfg_q.supported_major <= MAJOR_RST;
      cfg_q.max_payload <= MAX_PAYLOAD_RST;
    end else if (cfg_we_i) begin
      unique case (frdf_reg_e'(cfg_idx_i))
        REG_SYNC_FIRST:  cfg_q.sync_first <= cfg_wdata_i[7:0];
        REG_SYNC_SECOND: cfg_q.sync_second <= cfg_wdata_i[7:0];
        REG_MAJOR:       cfg_q.supported_major <= cfg_wdata_i[7:0];
        REG_MAX_PAYLOAD: cfg_q.max_payload <= cfg_wdata_i[15:0];
        default:         cfg_q <= cfg_q;
      endcase
    end
  end

  assign in_ready_o = (count_q <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
  assign in_acc = in_valid_i && in_ready_o;

  frdf_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_acc),
    .rx_byte_i    (rx_byte_i),
    .buffer_end_i (buffer_end_i),
    .cfg_i        (cfg_q),
    .push_o       (push)
  );

  assign n_push = {1'b0, push.pay_vld} + {1'b0, push.sts_vld};
  assign first_res = push.pay_vld ? push.pay : push.sts;
  assign head = fifo_q[rd_ptr_q];
  assign out_valid_o = (count_q != '0);
  assign pop = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      fifo_q[wr_ptr_q] <= first_res;
    end
    if (n_push == 2'd2) begin
      fifo_q[wr_ptr_q + FIFO_AW'(1)] <= push.sts;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + FIFO_AW'(n_push);
      rd_ptr_q <= rd_ptr_q + FIFO_AW'(pop);
      count_q <= count_q + (FIFO_AW+1)'(n_push) - (FIFO_AW+1)'(pop);
    end
  end

  assign item_kind_o = head.item_kind;
  assign payload_byte_o = head.payload_byte;
  assign status_code_o = head.status_code;
  assign major_version_o = head.major_version;
  assign family_code_o = head.family_code;
  assign msg_kind_o = head.msg_kind;
  assign queue_sel_o = head.queue_sel;
  assign header_flags_o = head.header_flags;
  assign sequence_no_o = head.sequence_no;
  assign payload_length_o = head.payload_length;
  assign run_last_o = head.run_last;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_push != 2'd0 |-> count_q <= (FIFO_AW+1)'(FIFO_DEPTH - 2))
    else $error("results pushed without room");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && item_kind_o == KIND_STATUS |-> run_last_o)
    else $error("status transaction not marked last");

  a_payload_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && item_kind_o == KIND_PAYLOAD |->
      status_code_o == ST_OK && payload_length_o == 16'd0)
    else $error("payload transaction carries status fields");

endmodule

### sv/frdf_parser.sv
// Frame parser state: byte position, running CRC, captured header and length.
// Produces the payload and status results of one accepted byte in the cycle it is accepted.
// Depends on frdf_pkg.
module frdf_parser
  import frdf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] rx_byte_i,
  input  logic       buffer_end_i,
  input  frdf_cfg_t  cfg_i,
  output frdf_push_t push_o
);

  logic [15:0] pos_q, pos_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  hdr_q [HDR_BYTES];
  logic [7:0]  hdr_d [HDR_BYTES];
  logic [15:0] len_q, len_d;
  logic [7:0]  crc_lo_q, crc_lo_d;
  logic        sync_ok_q, sync_ok_d;
  logic        crc_match_q, crc_match_d;

  logic [15:0] crc_u;
  logic [7:0]  hdr_u [HDR_BYTES];
  logic [15:0] len_u;
  logic [7:0]  crc_lo_u;
  logic        sync_ok_u;
  logic        crc_match_u;
  logic [15:0] count;
  logic [15:0] off;
  logic        pay_vld;
  frdf_status_e code;
  logic        show;

  always_comb begin
    crc_u = crc_q;
    hdr_u = hdr_q;
    len_u = len_q;
    crc_lo_u = crc_lo_q;
    sync_ok_u = sync_ok_q;
    crc_match_u = crc_match_q;
    pay_vld = 1'b0;
    off = pos_q - PAYLOAD_POS;
    if (pos_q != POS_LIMIT) begin
      count = pos_q + 16'd1;
      if (pos_q == 16'd0) begin
        sync_ok_u = (rx_byte_i == cfg_i.sync_first);
      end else if (pos_q == 16'd1) begin
        sync_ok_u = sync_ok_q && (rx_byte_i == cfg_i.sync_second);
      end else if (pos_q < PAYLOAD_POS) begin
        crc_u = crc16_byte(crc_q, rx_byte_i);
        for (int i = 0; i < HDR_BYTES; i++) begin
          if (pos_q[3:0] == HDR_FIRST_POS + 4'(i)) begin
            hdr_u[i] = rx_byte_i;
          end
        end
        if (pos_q[3:0] == LEN_LOW_POS) begin
          len_u = {8'h00, rx_byte_i};
        end else if (pos_q[3:0] == LEN_HIGH_POS) begin
          len_u = {rx_byte_i, len_q[7:0]};
        end
      end else begin
        if (off < len_q) begin
          crc_u = crc16_byte(crc_q, rx_byte_i);
          pay_vld = sync_ok_q && (len_q <= cfg_i.max_payload);
        end else if (off == len_q) begin
          crc_lo_u = rx_byte_i;
        end else if ({1'b0, off} == {1'b0, len_q} + 17'd1) begin
          crc_match_u = ({rx_byte_i, crc_lo_q} == crc_q);
        end
      end
    end else begin
      count = POS_LIMIT;
    end
  end

  always_comb begin
    show = 1'b0;
    if (count < MIN_FRAME) begin
      code = ST_TRUNCATED;
    end else if (!sync_ok_u) begin
      code = ST_BAD_SYNC;
    end else begin
      show = 1'b1;
      if (len_u > cfg_i.max_payload) begin
        code = ST_TOO_LONG;
      end else if ({1'b0, len_u} + {1'b0, MIN_FRAME} > {1'b0, count}) begin
        code = ST_TRUNCATED;
      end else if (!crc_match_u) begin
        code = ST_BAD_CRC;
      end else if (hdr_u[0] != cfg_i.supported_major) begin
        code = ST_BAD_MAJOR;
      end else if (hdr_u[1] == 8'd0 || hdr_u[1] > FAMILY_MAX) begin
        code = ST_UNKNOWN_FAMILY;
      end else begin
        code = ST_OK;
      end
    end
  end

  always_comb begin
    push_o = '0;
    push_o.pay_vld = accept_i && pay_vld;
    push_o.pay.item_kind = KIND_PAYLOAD;
    push_o.pay.status_code = ST_OK;
    push_o.pay.payload_byte = rx_byte_i;
    push_o.pay.run_last = !buffer_end_i;
    push_o.sts_vld = accept_i && buffer_end_i;
    push_o.sts.item_kind = KIND_STATUS;
    push_o.sts.status_code = code;
    push_o.sts.run_last = 1'b1;
    if (show) begin
      push_o.sts.major_version = hdr_u[0];
      push_o.sts.family_code = hdr_u[1];
      push_o.sts.msg_kind = hdr_u[2];
      push_o.sts.queue_sel = hdr_u[3];
      push_o.sts.header_flags = hdr_u[4];
      push_o.sts.sequence_no = hdr_u[5];
      push_o.sts.payload_length = len_u;
    end
  end

  always_comb begin
    pos_d = pos_q;
    crc_d = crc_q;
    hdr_d = hdr_q;
    len_d = len_q;
    crc_lo_d = crc_lo_q;
    sync_ok_d = sync_ok_q;
    crc_match_d = crc_match_q;
    if (accept_i) begin
      if (buffer_end_i) begin
        pos_d = '0;
        crc_d = CRC_INIT;
        for (int i = 0; i < HDR_BYTES; i++) begin
          hdr_d[i] = '0;
        end
        len_d = '0;
        crc_lo_d = '0;
        sync_ok_d = 1'b0;
        crc_match_d = 1'b0;
      end else begin
        pos_d = count;
        crc_d = crc_u;
        hdr_d = hdr_u;
        len_d = len_u;
        crc_lo_d = crc_lo_u;
        sync_ok_d = sync_ok_u;
        crc_match_d = crc_match_u;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      crc_q <= CRC_INIT;
      for (int i = 0; i < HDR_BYTES; i++) begin
        hdr_q[i] <= '0;
      end
      len_q <= '0;
      crc_lo_q <= '0;
      sync_ok_q <= 1'b0;
      crc_match_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      crc_q <= crc_d;
      hdr_q <= hdr_d;
      len_q <= len_d;
      crc_lo_q <= crc_lo_d;
      sync_ok_q <= sync_ok_d;
      crc_match_q <= crc_match_d;
    end
  end

endmodule
